// ----- src/knl_pkg.sv -----
// Shared types and constants for the keyframe blend pipeline.
package knl_pkg;

  typedef enum logic {
    OP_VEC  = 1'b0,
    OP_QUAT = 1'b1
  } op_t;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam int NORM_MSB = 29;
  localparam int ISQ_STEPS = 31;
  localparam int DIV_BITS = 17;

  typedef struct packed {
    op_t op;
    logic degen;
    logic [3:0] neg;
    logic [2:0][31:0] vres;
  } side_t;

endpackage

// ----- src/knl_blend.sv -----
// Weighted blend, dot product sign and vector rounding stages.
module knl_blend (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  knl_pkg::op_t op,
  input  logic [3:0][31:0] prev,
  input  logic [3:0][31:0] next,
  input  logic [16:0] lambda,
  output logic out_valid,
  output logic [3:0][49:0] blend,
  output knl_pkg::side_t side
);

  logic [16:0] lam_sat;
  logic [16:0] wa;
  logic va, vb;
  knl_pkg::op_t op_a, op_b;
  logic signed [49:0] pa [4];
  logic signed [49:0] nb [4];
  logic signed [63:0] dp [4];
  logic signed [49:0] cp [4];
  logic signed [49:0] cm [4];
  logic signed [64:0] d01, d23;
  logic signed [65:0] dot;
  logic signed [49:0] rnd [3];

  always_comb begin
    lam_sat = (lambda > knl_pkg::ONE_Q16) ? knl_pkg::ONE_Q16 : lambda;
    wa = knl_pkg::ONE_Q16 - lam_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_a <= op;
      for (int i = 0; i < 4; i++) begin
        pa[i] <= $signed(prev[i]) * $signed({1'b0, wa});
        nb[i] <= $signed(next[i]) * $signed({1'b0, lam_sat});
        dp[i] <= $signed(prev[i]) * $signed(next[i]);
      end
      op_b <= op_a;
      for (int i = 0; i < 4; i++) begin
        cp[i] <= pa[i] + nb[i];
        cm[i] <= pa[i] - nb[i];
      end
      d01 <= 65'(dp[0]) + 65'(dp[1]);
      d23 <= 65'(dp[2]) + 65'(dp[3]);
    end
  end

  always_comb begin
    dot = 66'(d01) + 66'(d23);
    for (int i = 0; i < 3; i++) begin
      rnd[i] = cp[i] + 50'sd32768;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        blend[i] <= dot[65] ? cm[i] : cp[i];
      end
      side.op <= op_b;
      side.degen <= 1'b0;
      side.neg <= '0;
      for (int i = 0; i < 3; i++) begin
        side.vres[i] <= rnd[i][47:16];
      end
    end
  end

endmodule

// ----- src/knl_norm.sv -----
// Magnitude, common normalizing shift and sum of squares stages.
module knl_norm (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [3:0][49:0] blend,
  input  knl_pkg::side_t in_side,
  output logic out_valid,
  output logic [3:0][29:0] dnorm,
  output logic [61:0] sumsq,
  output knl_pkg::side_t side
);

  logic [5:0] vs;
  knl_pkg::side_t sd_d, sd_e, sd_f, sd_g, sd_h;
  knl_pkg::side_t sd_i;
  knl_pkg::side_t sd_in;
  knl_pkg::side_t sd_fc;
  logic [48:0] mag_d [4];
  logic [48:0] mag_e [4];
  logic [48:0] mag_f [4];
  logic [48:0] orv;
  logic [5:0] msb;
  logic [5:0] msb_c;
  logic [29:0] d_g [4];
  logic [29:0] d_h [4];
  logic [29:0] d_i [4];
  logic [29:0] d_c [4];
  logic [59:0] sq [4];
  logic [60:0] s01, s23;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vs <= {vs[4:0], in_valid};
      out_valid <= vs[5];
    end
  end

  always_comb begin
    sd_in = in_side;
    for (int i = 0; i < 4; i++) begin
      sd_in.neg[i] = blend[i][49];
    end
    sd_fc = sd_e;
    sd_fc.degen = (sd_e.op == knl_pkg::OP_QUAT) && (orv == '0);
    msb_c = '0;
    for (int i = 0; i < 49; i++) begin
      if (orv[i]) begin
        msb_c = 6'(i);
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (msb >= 6'(knl_pkg::NORM_MSB)) begin
        d_c[i] = 30'(mag_f[i] >> (msb - 6'(knl_pkg::NORM_MSB)));
      end else begin
        d_c[i] = 30'(mag_f[i] << (6'(knl_pkg::NORM_MSB) - msb));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_d <= sd_in;
      for (int i = 0; i < 4; i++) begin
        mag_d[i] <= blend[i][49] ? 49'(-blend[i]) : blend[i][48:0];
      end
      sd_e <= sd_d;
      mag_e <= mag_d;
      orv <= mag_d[0] | mag_d[1] | mag_d[2] | mag_d[3];
      sd_f <= sd_fc;
      mag_f <= mag_e;
      msb <= msb_c;
      sd_g <= sd_f;
      d_g <= d_c;
      sd_h <= sd_g;
      d_h <= d_g;
      for (int i = 0; i < 4; i++) begin
        sq[i] <= d_g[i] * d_g[i];
      end
      sd_i <= sd_h;
      d_i <= d_h;
      s01 <= 61'(sq[0]) + 61'(sq[1]);
      s23 <= 61'(sq[2]) + 61'(sq[3]);
      side <= sd_i;
      for (int i = 0; i < 4; i++) begin
        dnorm[i] <= d_i[i];
      end
      sumsq <= 62'(s01) + 62'(s23);
    end
  end

endmodule

// ----- src/knl_isqrt.sv -----
// Integer square root, one result bit per pipeline stage.
module knl_isqrt (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [61:0] sumsq,
  input  logic [3:0][29:0] dnorm,
  input  knl_pkg::side_t in_side,
  output logic out_valid,
  output logic [30:0] root,
  output logic [3:0][29:0] dout,
  output knl_pkg::side_t side
);

  localparam int N = knl_pkg::ISQ_STEPS;

  logic [N:0] v;
  logic [61:0] x [N+1];
  logic [61:0] r [N+1];
  logic [3:0][29:0] dd [N+1];
  knl_pkg::side_t sd [N+1];

  assign v[0] = in_valid;
  assign x[0] = sumsq;
  assign r[0] = '0;
  assign dd[0] = dnorm;
  assign sd[0] = in_side;

  for (genvar t = 0; t < N; t++) begin : g_step
    localparam logic [61:0] BIT = 62'd1 << (2 * (N - 1 - t));
    logic [62:0] trial;
    assign trial = 63'(r[t]) + 63'(BIT);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[t+1] <= 1'b0;
      end else if (en) begin
        v[t+1] <= v[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dd[t+1] <= dd[t];
        sd[t+1] <= sd[t];
        if ({1'b0, x[t]} >= trial) begin
          x[t+1] <= 62'({1'b0, x[t]} - trial);
          r[t+1] <= (r[t] >> 1) + BIT;
        end else begin
          x[t+1] <= x[t];
          r[t+1] <= r[t] >> 1;
        end
      end
    end
  end

  assign out_valid = v[N];
  assign root = r[N][30:0];
  assign dout = dd[N];
  assign side = sd[N];

endmodule

// ----- src/knl_div.sv -----
// Restoring division of four lanes by twice the norm, plus the output register.
module knl_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [30:0] root,
  input  logic [3:0][29:0] dnorm,
  input  knl_pkg::side_t in_side,
  output logic out_valid,
  output logic [3:0][31:0] res,
  output logic degen
);

  localparam int N = knl_pkg::DIV_BITS;

  logic [N:0] v;
  logic [47:0] rem [N+1][4];
  logic [N-1:0] q [N+1][4];
  logic [31:0] den [N+1];
  knl_pkg::side_t sd [N+1];

  assign v[0] = in_valid;
  assign den[0] = {root, 1'b0};
  assign sd[0] = in_side;
  for (genvar i = 0; i < 4; i++) begin : g_init
    assign rem[0][i] = {1'b0, dnorm[i], 17'd0} + 48'(root);
    assign q[0][i] = '0;
  end

  for (genvar t = 0; t < N; t++) begin : g_step
    localparam int J = N - 1 - t;
    logic [48:0] dsh;
    assign dsh = 49'(den[t]) << J;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[t+1] <= 1'b0;
      end else if (en) begin
        v[t+1] <= v[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[t+1] <= den[t];
        sd[t+1] <= sd[t];
        for (int i = 0; i < 4; i++) begin
          if ({1'b0, rem[t][i]} >= dsh) begin
            rem[t+1][i] <= 48'({1'b0, rem[t][i]} - dsh);
            q[t+1][i] <= q[t][i] | (N'(1) << J);
          end else begin
            rem[t+1][i] <= rem[t][i];
            q[t+1][i] <= q[t][i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd[N].op == knl_pkg::OP_VEC) begin
        for (int i = 0; i < 3; i++) begin
          res[i] <= sd[N].vres[i];
        end
        res[3] <= '0;
        degen <= 1'b0;
      end else if (sd[N].degen) begin
        res <= '0;
        degen <= 1'b1;
      end else begin
        for (int i = 0; i < 4; i++) begin
          res[i] <= sd[N].neg[i] ? -32'(q[N][i]) : 32'(q[N][i]);
        end
        degen <= 1'b0;
      end
    end
  end

endmodule

// ----- src/keyframe_lerp_nlerp.sv -----
// Keyframe blend top level: linear vector blend and quaternion nlerp.
// Throughput is one word per cycle while the output is not stalled; the whole pipeline advances together.
// The square root takes 31 stages and the division 17, which set the depth.
// A stalled output freezes every stage, so nothing is lost or repeated.
// Synchronous reset clears all valid bits; data registers are not reset.
module keyframe_lerp_nlerp (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // prev_x, prev_y, prev_z, prev_w, next_x, next_y, next_z, next_w, lambda, zero pad
  input  logic [279:0] s_tdata,
  // opcode
  input  logic [0:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // res_x, res_y, res_z, res_w
  output logic [127:0] m_tdata,
  // degenerate
  output logic [0:0] m_tuser
);

  logic en;
  logic [3:0][31:0] prev, next;
  logic vb, vn, vs;
  logic [3:0][49:0] blend;
  knl_pkg::side_t sd_b, sd_n, sd_s;
  logic [3:0][29:0] dn, ds;
  logic [61:0] sumsq;
  logic [30:0] root;
  logic [3:0][31:0] res;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  for (genvar i = 0; i < 4; i++) begin : g_unpack
    assign prev[i] = s_tdata[32*i +: 32];
    assign next[i] = s_tdata[128 + 32*i +: 32];
    assign m_tdata[32*i +: 32] = res[i];
  end

  knl_blend u_blend (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid && s_tready),
    .op(knl_pkg::op_t'(s_tuser[0])), .prev(prev), .next(next),
    .lambda(s_tdata[272:256]), .out_valid(vb), .blend(blend), .side(sd_b)
  );

  knl_norm u_norm (
    .clk(clk), .rst(rst), .en(en), .in_valid(vb), .blend(blend), .in_side(sd_b),
    .out_valid(vn), .dnorm(dn), .sumsq(sumsq), .side(sd_n)
  );

  knl_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(vn), .sumsq(sumsq), .dnorm(dn),
    .in_side(sd_n), .out_valid(vs), .root(root), .dout(ds), .side(sd_s)
  );

  knl_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(vs), .root(root), .dnorm(ds),
    .in_side(sd_s), .out_valid(m_tvalid), .res(res), .degen(m_tuser[0])
  );

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("degenerate word carries nonzero data");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow pipeline advance");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the keyframe vector blend and quaternion nlerp unit.
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    knl_pkg::op_t op;
    logic [31:0] pv[4];
    logic [31:0] nv[4];
    logic [16:0] lam;
  } key_pair_t;

  typedef struct {
    logic [31:0] comp[4];
    logic        degen;
  } blend_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [279:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [0:0] m_tuser;

  key_pair_t pending_pairs[$];
  blend_t expected_blends[$];
  key_pair_t cur_pair;
  int errors = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;
  bit send_burst = 0;
  bit recv_burst = 0;
  string comp_names[4] = '{"res_x", "res_y", "res_z", "res_w"};

  keyframe_lerp_nlerp DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void queue_pair(key_pair_t kp);
    pending_pairs.insert(pending_pairs.size(), kp);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic blend_t predict_blend(key_pair_t kp);
    blend_t res;
    logic signed [63:0] p[4];
    logic signed [63:0] n[4];
    logic signed [63:0] c;
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [65:0] dot;
    logic [63:0] mag[4];
    logic [63:0] m;
    logic [63:0] s;
    logic [63:0] nrm;
    logic [63:0] q;
    bit ng[4];
    int rs;
    int ls;
    for (int i = 0; i < 4; i++) begin
      p[i] = $signed(kp.pv[i]);
      n[i] = $signed(kp.nv[i]);
    end
    wb = (kp.lam > knl_pkg::ONE_Q16) ? 64'sd65536 : $signed({47'd0, kp.lam});
    wa = 64'sd65536 - wb;
    res.degen = 1'b0;
    if (kp.op == knl_pkg::OP_VEC) begin
      for (int i = 0; i < 3; i++) begin
        c = p[i] * wa + n[i] * wb + 64'sd32768;
        c = c >>> 16;
        res.comp[i] = c[31:0];
      end
      res.comp[3] = '0;
      return res;
    end
    dot = 0;
    for (int i = 0; i < 4; i++) dot = dot + p[i] * n[i];
    m = 0;
    for (int i = 0; i < 4; i++) begin
      c = (dot >= 0) ? p[i] * wa + n[i] * wb : p[i] * wa - n[i] * wb;
      ng[i] = c < 0;
      mag[i] = ng[i] ? -c : c;
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 4; i++) res.comp[i] = '0;
      res.degen = 1'b1;
      return res;
    end
    rs = 0;
    ls = 0;
    while (m >= (64'd1 << 30)) begin
      m = m >> 1;
      rs++;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1;
      ls++;
    end
    s = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (mag[i] >> rs) << ls;
      s = s + mag[i] * mag[i];
    end
    nrm = int_sqrt(s);
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << 17) + nrm) / (2 * nrm);
      res.comp[i] = ng[i] ? 32'(-q) : q[31:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] pick_comp(int style);
    case (style)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      2: return 32'($signed($urandom_range(0, 512)) - 256);
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
    endcase
  endfunction

  function automatic key_pair_t make_pair(knl_pkg::op_t op, logic [31:0] p0,
                                          logic [31:0] p1, logic [31:0] p2,
                                          logic [31:0] p3, logic [31:0] n0,
                                          logic [31:0] n1, logic [31:0] n2, logic [31:0] n3,
                                          logic [16:0] lam);
    key_pair_t kp;
    kp.op = op;
    kp.pv = '{p0, p1, p2, p3};
    kp.nv = '{n0, n1, n2, n3};
    kp.lam = lam;
    return kp;
  endfunction

  function automatic key_pair_t random_pair();
    key_pair_t kp;
    int style;
    int rel;
    style = $urandom_range(0, 4);
    if (style == 4) style = $urandom_range(0, 3);
    kp.op = knl_pkg::op_t'($urandom_range(0, 1));
    for (int i = 0; i < 4; i++) kp.pv[i] = pick_comp(style);
    rel = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      case (rel)
        0: kp.nv[i] = kp.pv[i] + 32'($signed($urandom_range(0, 64)) - 32);
        1: kp.nv[i] = -kp.pv[i] + 32'($signed($urandom_range(0, 64)) - 32);
        default: kp.nv[i] = pick_comp($urandom_range(0, 3));
      endcase
    end
    case ($urandom_range(0, 7))
      0: kp.lam = 17'd0;
      1: kp.lam = knl_pkg::ONE_Q16;
      2: kp.lam = $urandom_range(65537, 131071);
      3: kp.lam = 17'd32768;
      default: kp.lam = $urandom_range(0, 65536);
    endcase
    return kp;
  endfunction

  initial begin
    queue_pair(make_pair(knl_pkg::OP_VEC, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5, 0));
    queue_pair(make_pair(knl_pkg::OP_VEC, 32'h7FFF_FFFF, 32'h8000_0000, 1, 9,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 7,
                         knl_pkg::ONE_Q16));
    queue_pair(make_pair(knl_pkg::OP_VEC, 1, 32'hFFFF_FFFF, 3, 0, 0, 0, 0, 0,
                         17'd32768));
    queue_pair(make_pair(knl_pkg::OP_VEC, 32'h7FFF_FFFF, 32'h8000_0000, 2, 0,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 0,
                         17'h1FFFF));
    queue_pair(make_pair(knl_pkg::OP_VEC, 5, 6, 7, 32'h1234_5678, 8, 9, 10,
                         32'h8765_4321, 17'd1));
    queue_pair(make_pair(knl_pkg::OP_QUAT, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0));
    queue_pair(make_pair(knl_pkg::OP_QUAT, 0, 0, 0, 0, 0, 0, 0, 0, 17'd32768));
    queue_pair(make_pair(knl_pkg::OP_QUAT, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0,
                         knl_pkg::ONE_Q16));
    queue_pair(make_pair(knl_pkg::OP_QUAT, 32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000,
                         0, 0, 17'd32768));
    queue_pair(make_pair(knl_pkg::OP_QUAT, 32'h0001_0000, 0, 0, 0, 32'hFFFF_0000,
                         32'h0000_0100, 0, 0, 17'd32768));
    queue_pair(make_pair(knl_pkg::OP_QUAT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 17'd40000));
    queue_pair(make_pair(knl_pkg::OP_QUAT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF, 17'h1FFFF));
    queue_pair(make_pair(knl_pkg::OP_QUAT, 1, 0, 0, 0, 0, 0, 0, 1, 17'd1));
    queue_pair(make_pair(knl_pkg::OP_QUAT, 3, 32'hFFFF_FFFD, 2, 32'hFFFF_FFFE,
                         3, 32'hFFFF_FFFD, 2, 32'hFFFF_FFFE, 17'd65535));
    for (int i = 0; i < 1900; i++) queue_pair(random_pair());
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_pairs.size() != 0 || s_tvalid || expected_blends.size() != 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  function automatic int draw_wait(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 16);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      expected_blends.insert(expected_blends.size(), predict_blend(cur_pair));
      if ($urandom_range(0, 40) == 0) send_burst = !send_burst;
      send_gap = draw_wait(send_burst);
      if (send_gap == 0 && pending_pairs.size() != 0) begin
        cur_pair = pending_pairs.pop_front();
        s_tdata <= {7'd0, cur_pair.lam, cur_pair.nv[3], cur_pair.nv[2], cur_pair.nv[1],
                    cur_pair.nv[0], cur_pair.pv[3], cur_pair.pv[2], cur_pair.pv[1],
                    cur_pair.pv[0]};
        s_tuser <= cur_pair.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end else if (!s_tvalid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_pairs.size() != 0) begin
        cur_pair = pending_pairs.pop_front();
        s_tdata <= {7'd0, cur_pair.lam, cur_pair.nv[3], cur_pair.nv[2], cur_pair.nv[1],
                    cur_pair.nv[0], cur_pair.pv[3], cur_pair.pv[2], cur_pair.pv[1],
                    cur_pair.pv[0]};
        s_tuser <= cur_pair.op;
        s_tvalid <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    blend_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_blends.size() == 0) begin
          $error("unexpected output word: data %h user %b", m_tdata, m_tuser);
          errors++;
        end else begin
          want = expected_blends.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (m_tdata[32*i +: 32] !== want.comp[i]) begin
              $error("%s expected %h actual %h", comp_names[i], want.comp[i],
                     m_tdata[32*i +: 32]);
              errors++;
            end
          end
          if (m_tuser[0] !== want.degen) begin
            $error("degenerate expected %b actual %b", want.degen, m_tuser[0]);
            errors++;
          end
        end
        if ($urandom_range(0, 40) == 0) recv_burst = !recv_burst;
        recv_stall = draw_wait(recv_burst);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      m_tready <= (recv_stall == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 3000) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
